[hdl/pn3_pkg.sv]
`timescale 1ns / 1ps
package pn3_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 24;
    localparam int TDATA_IN_W    = 96;
    localparam int TDATA_OUT_W   = 16;
    localparam logic CMD_EVAL    = 1'b0;
    localparam logic CMD_LOAD    = 1'b1;
endpackage

[hdl/perlin_noise_3d.sv]
`timescale 1ns / 1ps
// Load item: written straight into the permutation memory; loads go back to back.
// Evaluate item: fade, hash, gradient, lerp and output states in turn, then back in idle,
// so the next evaluate item waits until the last is through, while the output is taken at once.
// The rate is set by fourteen reads of the single-port table and by one shared multiplier.
// The result sits in an output register; the next item is taken while it waits.
// Synchronous active-low reset clears control state only; the table is undefined until loaded.
module perlin_noise_3d #(
    parameter int FRAC_BITS = pn3_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: table_index[7:0], table_value[15:8], x_coord[39:16],
    //        y_coord[63:40], z_coord[87:64], zero fill [95:88]
    input  logic [pn3_pkg::TDATA_IN_W-1:0]   s_axis_tdata,
    // tuser: command
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: noise_value
    output logic [pn3_pkg::TDATA_OUT_W-1:0]  m_axis_tdata
);
    import pn3_pkg::*;

    localparam int W    = FRAC_BITS + 6;   // signed working width, values within +-32
    localparam int PW   = 2 * W;
    localparam int SW   = W + 9;           // room for the left shift of small fractions
    localparam logic signed [W-1:0] ONE = W'(1) << FRAC_BITS;

    // states
    localparam logic [3:0] S_IDLE = 4'd0, S_FADE = 4'd1, S_HASH = 4'd2, S_GRAD = 4'd3,
                           S_LERP = 4'd4, S_OUT = 4'd5;

    logic [7:0] r_mem [0:255];
    logic [7:0] r_rdata;
    logic [7:0] n_raddr;
    logic       n_rd;

    logic [3:0]  r_state, n_state;
    logic [4:0]  r_step, n_step;
    logic        r_wait, n_wait;  // read issued, data next cycle
    logic [7:0]  r_cx, r_cy, r_cz;
    logic signed [W-1:0] r_fx, r_fy, r_fz;
    logic signed [W-1:0] r_u, r_v, r_w;
    logic signed [W-1:0] r_t2, r_t3, r_k;
    logic [7:0]  r_a, r_b, r_aa, r_ab, r_ba, r_bb;
    logic signed [W-1:0] r_g [0:7];
    logic signed [W-1:0] r_l [0:3];
    logic signed [W-1:0] r_m0, r_m1;
    logic [15:0] r_out;
    logic        r_ovalid;

    logic signed [W-1:0] n_u, n_v, n_w, n_t2, n_t3, n_k, n_m0, n_m1;
    logic [7:0]  n_a, n_b, n_aa, n_ab, n_ba, n_bb;
    logic signed [W-1:0] n_l [0:3];
    logic signed [W-1:0] n_g [0:7];
    logic [15:0] n_out;
    logic        n_ovalid;

    // coordinates widened so that bits above the field read as zero
    logic [31:0] x_ext, y_ext, z_ext;
    assign x_ext = {8'd0, s_axis_tdata[16 +: COORD_W]};
    assign y_ext = {8'd0, s_axis_tdata[40 +: COORD_W]};
    assign z_ext = {8'd0, s_axis_tdata[64 +: COORD_W]};

    // shared multiplier with floor shift, operands selected combinationally from registered values
    logic signed [W-1:0] mul_a, mul_b, mul_q;
    logic signed [PW-1:0] mul_p;
    assign mul_p = PW'(mul_a) * PW'(mul_b);
    assign mul_q = W'(mul_p >>> FRAC_BITS);

    logic signed [W-1:0] cur_t;
    logic [1:0] fsel;
    logic [2:0] gsel;
    logic [3:0] hh;
    logic signed [W-1:0] gx, gy, gz, gu, gv, gval;
    logic signed [W+1:0] s_ext;
    logic signed [SW-1:0] s_sh;

    wire in_acc  = s_axis_tvalid && s_axis_tready;
    wire is_load = s_axis_tuser == CMD_LOAD;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (in_acc && is_load)
            r_mem[s_axis_tdata[7:0]] <= s_axis_tdata[15:8];
        if (n_rd)
            r_rdata <= r_mem[n_raddr];
    end

    // gradient for corner gsel: bit0 -> x1, bit1 -> y1, bit2 -> z1
    always_comb begin
        gx = gsel[0] ? r_fx - ONE : r_fx;
        gy = gsel[1] ? r_fy - ONE : r_fy;
        gz = gsel[2] ? r_fz - ONE : r_fz;
        hh = r_rdata[3:0];
        gu = (hh < 4'd8) ? gx : gy;
        if (hh < 4'd4)
            gv = gy;
        else if (hh == 4'd12 || hh == 4'd14)
            gv = gx;
        else
            gv = gz;
        gval = (hh[0] ? -gu : gu) + (hh[1] ? -gv : gv);
    end

    always_comb begin
        n_state = r_state; n_step = r_step; n_wait = 1'b0;
        n_u = r_u; n_v = r_v; n_w = r_w; n_t2 = r_t2; n_t3 = r_t3; n_k = r_k;
        n_a = r_a; n_b = r_b; n_aa = r_aa; n_ab = r_ab; n_ba = r_ba; n_bb = r_bb;
        n_l = r_l; n_g = r_g; n_m0 = r_m0; n_m1 = r_m1;
        n_out = r_out; n_ovalid = r_ovalid && !m_axis_tready;
        n_rd = 1'b0; n_raddr = '0;
        mul_a = '0; mul_b = '0; gsel = '0; fsel = '0; cur_t = '0;
        s_ext = '0; s_sh = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && !is_load) begin
                    n_state = S_FADE; n_step = '0;
                end
            end
            S_FADE: begin
                // four products per coordinate: t2, t3, k, fade
                fsel = r_step[3:2];
                unique case (fsel)
                    2'd0: cur_t = r_fx;
                    2'd1: cur_t = r_fy;
                    default: cur_t = r_fz;
                endcase
                unique case (r_step[1:0])
                    2'd0: begin mul_a = cur_t; mul_b = cur_t; n_t2 = mul_q; end
                    2'd1: begin mul_a = r_t2; mul_b = cur_t; n_t3 = mul_q; end
                    2'd2: begin
                        mul_a = cur_t;
                        mul_b = W'(cur_t * 6) - W'(ONE * 15);
                        n_k = mul_q;
                    end
                    default: begin
                        mul_a = r_t3; mul_b = r_k + W'(ONE * 10);
                        unique case (fsel)
                            2'd0: n_u = mul_q;
                            2'd1: n_v = mul_q;
                            default: n_w = mul_q;
                        endcase
                    end
                endcase
                n_step = r_step + 5'd1;
                if (r_step == 5'd11) begin
                    n_state = S_HASH; n_step = '0;
                end
            end
            S_HASH: begin
                // issue read, consume next cycle: perm(X), perm(X+1), perm(a), perm(a+1),
                // perm(b), perm(b+1)
                if (!r_wait) begin
                    n_rd = 1'b1; n_wait = 1'b1;
                    unique case (r_step[2:0])
                        3'd0: n_raddr = r_cx;
                        3'd1: n_raddr = r_cx + 8'd1;
                        3'd2: n_raddr = r_a;
                        3'd3: n_raddr = r_a + 8'd1;
                        3'd4: n_raddr = r_b;
                        default: n_raddr = r_b + 8'd1;
                    endcase
                end else begin
                    unique case (r_step[2:0])
                        3'd0: n_a  = r_rdata + r_cy;
                        3'd1: n_b  = r_rdata + r_cy;
                        3'd2: n_aa = r_rdata + r_cz;
                        3'd3: n_ab = r_rdata + r_cz;
                        3'd4: n_ba = r_rdata + r_cz;
                        default: n_bb = r_rdata + r_cz;
                    endcase
                    n_step = r_step + 5'd1;
                    if (r_step == 5'd5) begin
                        n_state = S_GRAD; n_step = '0;
                    end
                end
            end
            S_GRAD: begin
                // corner index: bit0 x side, bit1 y side, bit2 z side
                gsel = r_step[2:0];
                if (!r_wait) begin
                    n_rd = 1'b1; n_wait = 1'b1;
                    unique case (r_step[1:0])
                        2'd0: n_raddr = r_aa;
                        2'd1: n_raddr = r_ba;
                        2'd2: n_raddr = r_ab;
                        default: n_raddr = r_bb;
                    endcase
                    if (r_step[2])
                        n_raddr = n_raddr + 8'd1;
                end else begin
                    n_g[r_step[2:0]] = gval;
                    n_step = r_step + 5'd1;
                    if (r_step == 5'd7) begin
                        n_state = S_LERP; n_step = '0;
                    end
                end
            end
            S_LERP: begin
                unique case (r_step[2:0])
                    3'd0: begin mul_a = r_u; mul_b = r_g[1] - r_g[0]; n_l[0] = r_g[0] + mul_q; end
                    3'd1: begin mul_a = r_u; mul_b = r_g[3] - r_g[2]; n_l[1] = r_g[2] + mul_q; end
                    3'd2: begin mul_a = r_u; mul_b = r_g[5] - r_g[4]; n_l[2] = r_g[4] + mul_q; end
                    3'd3: begin mul_a = r_u; mul_b = r_g[7] - r_g[6]; n_l[3] = r_g[6] + mul_q; end
                    3'd4: begin mul_a = r_v; mul_b = r_l[1] - r_l[0]; n_m0 = r_l[0] + mul_q; end
                    3'd5: begin mul_a = r_v; mul_b = r_l[3] - r_l[2]; n_m1 = r_l[2] + mul_q; end
                    default: begin mul_a = r_w; mul_b = r_m1 - r_m0; n_m0 = r_m0 + mul_q; end
                endcase
                n_step = r_step + 5'd1;
                if (r_step == 5'd6)
                    n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_ovalid || m_axis_tready) begin
                    s_ext = (W+2)'(r_m0) + (W+2)'(ONE);
                    if (FRAC_BITS <= 15)
                        s_sh = SW'(s_ext) <<< (15 - FRAC_BITS);
                    else
                        s_sh = SW'(s_ext >>> (FRAC_BITS - 15));
                    if (s_ext <= 0)
                        n_out = '0;
                    else if (s_sh > 65535)
                        n_out = 16'hFFFF;
                    else
                        n_out = s_sh[15:0];
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_step <= '0; r_wait <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_step <= n_step; r_wait <= n_wait; r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && !is_load) begin
            r_cx <= x_ext[FRAC_BITS +: 8];
            r_cy <= y_ext[FRAC_BITS +: 8];
            r_cz <= z_ext[FRAC_BITS +: 8];
            r_fx <= W'({1'b0, s_axis_tdata[16 +: FRAC_BITS]});
            r_fy <= W'({1'b0, s_axis_tdata[40 +: FRAC_BITS]});
            r_fz <= W'({1'b0, s_axis_tdata[64 +: FRAC_BITS]});
        end
        r_u <= n_u; r_v <= n_v; r_w <= n_w; r_t2 <= n_t2; r_t3 <= n_t3; r_k <= n_k;
        r_a <= n_a; r_b <= n_b; r_aa <= n_aa; r_ab <= n_ab; r_ba <= n_ba; r_bb <= n_bb;
        r_l <= n_l; r_g <= n_g; r_m0 <= n_m0; r_m1 <= n_m1; r_out <= n_out;
    end
endmodule
